FILE: rtl/ifpe_pkg.sv
// Package for the IR frame pulse encoder: word types, register indexes,
// configuration record and job record shared by all modules.
// Depends on nothing.
package ifpe_pkg;

	localparam int DUR_W       = 15;
	localparam int CFG_IDX_W   = 3;
	localparam int WAKE_PULSES = 5;
	localparam int WAKE_CNT_W  = 4;
	localparam int JOBQ_DEPTH  = 4;
	localparam int JOBQ_PTR_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MARK         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WAKE_TRAILER_SPACE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP_SPACE    = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_index;
		logic       first_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [DUR_W-1:0] mark_time;
		logic [DUR_W-1:0] space_time;
		logic             run_end;
	} out_word_t;

	typedef struct packed {
		logic [DUR_W-1:0] header_mark;
		logic [DUR_W-1:0] header_space;
		logic [DUR_W-1:0] bit_mark;
		logic [DUR_W-1:0] one_space;
		logic [DUR_W-1:0] zero_space;
		logic [DUR_W-1:0] short_mark;
		logic [DUR_W-1:0] wake_trailer_space;
		logic [DUR_W-1:0] frame_gap_space;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] sum_byte;
		logic       second;
		logic       first;
		logic       last;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_req_t;

endpackage

FILE: rtl/ifpe_cfg_regs.sv
// Configuration register file of the IR frame pulse encoder.
// Depends on ifpe_pkg.
module ifpe_cfg_regs
	import ifpe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DUR_W-1:0]      cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_mark        <= 15'd3500;
			cfg_q.header_space       <= 15'd1728;
			cfg_q.bit_mark           <= 15'd428;
			cfg_q.one_space          <= 15'd1280;
			cfg_q.zero_space         <= 15'd428;
			cfg_q.short_mark         <= 15'd428;
			cfg_q.wake_trailer_space <= 15'd25000;
			cfg_q.frame_gap_space    <= 15'd29000;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_HEADER_MARK:        cfg_q.header_mark        <= cfg_data;
				REG_HEADER_SPACE:       cfg_q.header_space       <= cfg_data;
				REG_BIT_MARK:           cfg_q.bit_mark           <= cfg_data;
				REG_ONE_SPACE:          cfg_q.one_space          <= cfg_data;
				REG_ZERO_SPACE:         cfg_q.zero_space         <= cfg_data;
				REG_SHORT_MARK:         cfg_q.short_mark         <= cfg_data;
				REG_WAKE_TRAILER_SPACE: cfg_q.wake_trailer_space <= cfg_data;
				REG_FRAME_GAP_SPACE:    cfg_q.frame_gap_space    <= cfg_data;
				default:                cfg_q.header_mark        <= cfg_q.header_mark;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/ifpe_front.sv
// Front end of the IR frame pulse encoder: accepts input words, keeps the
// running frame checksum and turns each word into a job.
// Depends on ifpe_pkg.
module ifpe_front
	import ifpe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_word_t in_word,
	input  logic     jobq_full,
	output logic     full,
	output job_req_t enq
);

	logic [7:0] sum_q;
	logic [7:0] sum_next;
	logic       accept;

	assign accept   = push && !jobq_full;
	assign sum_next = (in_word.first_byte ? 8'd0 : sum_q) + in_word.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= 8'd0;
		end else if (accept) begin
			sum_q <= in_word.last_byte ? 8'd0 : sum_next;
		end
	end

	assign full              = jobq_full;
	assign enq.valid         = accept;
	assign enq.job.data_byte = in_word.data_byte;
	assign enq.job.sum_byte  = sum_next;
	assign enq.job.second    = in_word.frame_index;
	assign enq.job.first     = in_word.first_byte;
	assign enq.job.last      = in_word.last_byte;

endmodule

FILE: rtl/ifpe_job_queue.sv
// Short job queue between the front end and the symbol sequencer.
// Depends on ifpe_pkg.
module ifpe_job_queue
	import ifpe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  job_req_t enq,
	input  logic     deq,
	output logic     full,
	output logic     empty,
	output job_t     head
);

	job_t                mem [JOBQ_DEPTH];
	logic [JOBQ_PTR_W:0] wr_ptr_q;
	logic [JOBQ_PTR_W:0] rd_ptr_q;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[JOBQ_PTR_W] != rd_ptr_q[JOBQ_PTR_W]) &&
	               (wr_ptr_q[JOBQ_PTR_W-1:0] == rd_ptr_q[JOBQ_PTR_W-1:0]);
	assign head  = mem[rd_ptr_q[JOBQ_PTR_W-1:0]];

	always_ff @(posedge clk) begin
		if (enq.valid) begin
			mem[wr_ptr_q[JOBQ_PTR_W-1:0]] <= enq.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (enq.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/ifpe_back.sv
// Symbol sequencer of the IR frame pulse encoder: walks one job through its
// preamble if opening, data bits, then checksum bits and end pulse if closing,
// one symbol per cycle while the output is popped. Depends on ifpe_pkg.
module ifpe_back
	import ifpe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      jobq_empty,
	input  job_t      jobq_head,
	output logic      deq,
	input  logic      pop,
	output logic      empty,
	output out_word_t out_word
);

	typedef enum logic [5:0] {
		PH_WAKE    = 6'b000001,
		PH_TRAILER = 6'b000010,
		PH_HEADER  = 6'b000100,
		PH_DATA    = 6'b001000,
		PH_SUM     = 6'b010000,
		PH_END     = 6'b100000
	} phase_t;

	localparam logic                  WAKE_ON   = (WAKE_PULSES != 0);
	localparam logic [WAKE_CNT_W-1:0] WAKE_LAST = WAKE_CNT_W'(WAKE_PULSES - 1);

	logic                  busy_q;
	job_t                  job_q;
	phase_t                phase_q;
	phase_t                phase_next;
	phase_t                phase_start;
	logic [WAKE_CNT_W-1:0] cnt_q;
	logic [WAKE_CNT_W-1:0] cnt_next;
	logic                  out_valid_q;
	out_word_t             out_q;
	out_word_t             sym;
	logic                  advance;
	logic                  is_final;
	logic                  load;
	logic                  bit_val;

	assign advance = busy_q && (!out_valid_q || pop);
	assign load    = !jobq_empty && (!busy_q || (advance && is_final));
	assign deq     = load;

	always_comb begin
		bit_val  = 1'b0;
		is_final = 1'b0;
		sym      = '0;
		unique case (phase_q)
			PH_WAKE: begin
				sym.mark_time  = cfg.short_mark;
				sym.space_time = cfg.zero_space;
			end
			PH_TRAILER: begin
				sym.mark_time  = cfg.short_mark;
				sym.space_time = cfg.wake_trailer_space;
			end
			PH_HEADER: begin
				sym.mark_time  = cfg.header_mark;
				sym.space_time = cfg.header_space;
			end
			PH_DATA: begin
				bit_val        = job_q.data_byte[cnt_q[2:0]];
				sym.mark_time  = cfg.bit_mark;
				sym.space_time = bit_val ? cfg.one_space : cfg.zero_space;
				is_final       = (cnt_q[2:0] == 3'd7) && !job_q.last;
			end
			PH_SUM: begin
				bit_val        = job_q.sum_byte[cnt_q[2:0]];
				sym.mark_time  = cfg.bit_mark;
				sym.space_time = bit_val ? cfg.one_space : cfg.zero_space;
			end
			PH_END: begin
				sym.mark_time  = cfg.short_mark;
				sym.space_time = job_q.second ? cfg.zero_space : cfg.frame_gap_space;
				is_final       = 1'b1;
			end
			default: begin
				sym = '0;
			end
		endcase
		sym.run_end = is_final;
	end

	always_comb begin
		phase_next = phase_q;
		cnt_next   = cnt_q + 1'b1;
		unique case (phase_q)
			PH_WAKE: begin
				if (cnt_q == WAKE_LAST) begin
					phase_next = PH_TRAILER;
					cnt_next   = '0;
				end
			end
			PH_TRAILER: begin
				phase_next = PH_HEADER;
				cnt_next   = '0;
			end
			PH_HEADER: begin
				phase_next = PH_DATA;
				cnt_next   = '0;
			end
			PH_DATA: begin
				if (cnt_q[2:0] == 3'd7) begin
					phase_next = PH_SUM;
					cnt_next   = '0;
				end
			end
			PH_SUM: begin
				if (cnt_q[2:0] == 3'd7) begin
					phase_next = PH_END;
					cnt_next   = '0;
				end
			end
			PH_END: begin
				cnt_next = '0;
			end
			default: begin
				phase_next = PH_DATA;
				cnt_next   = '0;
			end
		endcase
	end

	always_comb begin
		if (jobq_head.first && !jobq_head.second) begin
			phase_start = WAKE_ON ? PH_WAKE : PH_TRAILER;
		end else if (jobq_head.first) begin
			phase_start = PH_HEADER;
		end else begin
			phase_start = PH_DATA;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= jobq_head;
		end
		if (advance) begin
			out_q <= sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_DATA;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q  <= 1'b1;
				phase_q <= phase_start;
				cnt_q   <= '0;
			end else if (advance) begin
				busy_q  <= !is_final;
				phase_q <= phase_next;
				cnt_q   <= cnt_next;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty    = !out_valid_q;
	assign out_word = out_q;

endmodule

FILE: rtl/ir_frame_pulse_encoder_unit.sv
// Top level of the IR frame pulse encoder: configuration registers, front
// end, job queue and symbol sequencer.
// Depends on ifpe_pkg, ifpe_cfg_regs, ifpe_front, ifpe_job_queue, ifpe_back.
//
// Usage: payload bytes of a two-frame command enter as words on the push/full
// side; each byte carries its frame index and first/last flags. The block
// emits one mark/space word per symbol on the empty/pop side, and run_end
// marks the last symbol caused by an input word. A frame-one opening byte
// gives the wake pulses, the trailer and a header before its eight bits; a
// frame-two opening byte gives a header; a closing byte adds eight checksum
// bits and an end pulse. Registers are written through cfg_write, cfg_index
// and cfg_data while the block is idle; the user, not the block, ensures it.
// An accepted word is written into the job queue, loaded into the job
// register of the sequencer and its first symbol registered in the output
// word. Throughput: one symbol per cycle while the output is popped; a
// word gives 8 to WAKE_PULSES + 19 symbols (8 to 24 here), and a four-deep
// job queue lets the front keep accepting words meanwhile. When the receiver
// stalls, the output word holds and the sequencer waits; full rises once
// the job queue holds four words. Reset clears the checksum and the queue,
// empties the output and loads the default durations into the registers.
module ir_frame_pulse_encoder_unit
	import ifpe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DUR_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  in_word_t             in_word,
	output logic                 empty,
	input  logic                 pop,
	output out_word_t            out_word
);

	cfg_t     cfg;
	job_req_t enq;
	logic     jobq_full;
	logic     jobq_empty;
	job_t     jobq_head;
	logic     deq;

	ifpe_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ifpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_word   (in_word),
		.jobq_full (jobq_full),
		.full      (full),
		.enq       (enq)
	);

	ifpe_job_queue u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.enq    (enq),
		.deq    (deq),
		.full   (jobq_full),
		.empty  (jobq_empty),
		.head   (jobq_head)
	);

	ifpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.jobq_empty (jobq_empty),
		.jobq_head  (jobq_head),
		.deq        (deq),
		.pop        (pop),
		.empty      (empty),
		.out_word   (out_word)
	);

endmodule

FILE: rtl/ifpe_checker.sv
// Port checker for the IR frame pulse encoder, bound to the top level.
// Depends on ifpe_pkg and ir_frame_pulse_encoder_unit.
module ifpe_checker
	import ifpe_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 push,
	input logic                 full,
	input logic                 empty,
	input logic                 pop,
	input out_word_t            out_word
);

	a_word_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("Waiting word withdrawn.");

	a_word_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(out_word))
		else $error("Waiting word changed.");

	a_run_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !out_word.run_end |=> !empty)
		else $error("Gap inside a symbol run.");

	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		!full && !push |=> !full)
		else $error("Queue filled without a push.");

endmodule

bind ir_frame_pulse_encoder_unit ifpe_checker u_ifpe_checker (.*);
